// ===== rtl/lobm_pkg.sv =====
// package: shared types, codes and defaults of the limit order book matcher
`timescale 1ns / 1ps
package lobm_pkg;

    localparam int BOOK_ENTRIES_DEF = 32;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_AMEND  = 2'd1;
    localparam logic [1:0] CMD_PULL   = 2'd2;
    localparam logic [1:0] CMD_BAD    = 2'd3;

    typedef enum logic [2:0] {
        ST_RESTED    = 3'd0,
        ST_FILLED    = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_UNKNOWN   = 3'd3,
        ST_FULL      = 3'd4,
        ST_BAD_CMD   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_MATCH,
        S_FILL,
        S_FREE,
        S_DONE,
        S_OUT
    } state_t;

    // one resting order
    typedef struct packed {
        logic [31:0] order_id;
        logic [7:0]  symbol;
        logic        side;
        logic [31:0] price;
        logic [31:0] volume;
        logic [31:0] stamp;
    } entry_t;

    // book write port controls
    typedef struct packed {
        logic we;
        logic set_valid;
        logic clr_valid;
    } book_wr_t;

endpackage

// ===== rtl/limit_order_book_matcher_top.sv =====
// top level: sequencer of the price-time priority limit order book matcher
`timescale 1ns / 1ps
//
// channel  dir  tdata                                 tuser      tlast
// s_       in   id, symbol, side, price, quantity     command    -
// m_       out  status, aggr, passive, sym, px, vol   kind       last
//
// a request is taken only in idle; a bad command goes straight to its status,
// others get one id lookup scan, then per fill one book scan, one update of the
// resting entry and the trade transaction, a final match scan, for an insert with
// quantity left a free-slot scan, then the status and its transaction
// the book scans through one memory read port and the shared compare unit
// reset empties the book at once through the valid flags, no clearing pass
// a stalled m_tready holds the sequencer in its output wait state
module limit_order_book_matcher_top #(
    parameter int BOOK_ENTRIES = lobm_pkg::BOOK_ENTRIES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // order_id[31:0], symbol_index[39:32], side[40], limit_price[72:41],
    // quantity[104:73], zero fill
    input  logic [111:0] s_tdata,
    // command[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], aggressor_id[34:3], passive_id[66:35], trade_symbol[74:67],
    // trade_price[106:75], trade_volume[138:107], zero fill
    output logic [143:0] m_tdata,
    // kind[0]
    output logic         m_tuser,
    output logic         m_tlast
);
    import lobm_pkg::*;

    localparam int IDX_W = (BOOK_ENTRIES > 1) ? $clog2(BOOK_ENTRIES) : 1;
    localparam int CNT_W = $clog2(BOOK_ENTRIES + 1);
    localparam logic [CNT_W-1:0] N_CNT = CNT_W'(BOOK_ENTRIES);

    // sequencer state
    state_t state_reg, state_next;

    // request context
    logic [1:0]  cmd_reg, cmd_next;
    logic [31:0] id_reg, id_next;
    logic [7:0]  sym_reg, sym_next;
    logic        side_reg, side_next;
    logic [31:0] price_reg, price_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [31:0] seq_reg, seq_next;

    // lookup result
    logic             found_reg, found_next;
    logic [IDX_W-1:0] eidx_reg, eidx_next;
    entry_t           ent_reg, ent_next;

    // scan control
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pvld_reg, pvld_next;
    logic [IDX_W-1:0] pidx_reg, pidx_next;

    // best candidate and free slot
    logic             have_best_reg, have_best_next;
    logic [IDX_W-1:0] bidx_reg, bidx_next;
    entry_t           best_reg, best_next;
    logic             free_ok_reg, free_ok_next;
    logic [IDX_W-1:0] fidx_reg, fidx_next;

    // output register and return path after the transaction
    logic         out_valid_reg, out_valid_next;
    logic [138:0] out_data_reg, out_data_next;
    logic         out_kind_reg, out_kind_next;
    logic         ret_match_reg, ret_match_next;

    // book interface
    logic [IDX_W-1:0]        rd_addr;
    entry_t                  rd_data;
    book_wr_t                wr_ctl;
    logic [IDX_W-1:0]        wr_addr;
    entry_t                  wr_data;
    logic [BOOK_ENTRIES-1:0] valid;

    logic take;
    logic scan_done;
    logic cand_valid;
    logic [31:0] fill_vol;
    logic        new_stamp;
    status_t     st;
    logic [7:0]  st_sym;
    logic [31:0] st_price;
    logic [31:0] st_vol;

    lobm_book #(
        .BOOK_ENTRIES(BOOK_ENTRIES)
    ) u_book (
        .aclk   (aclk),
        .aresetn(aresetn),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .wr_ctl (wr_ctl),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .valid  (valid)
    );

    assign cand_valid = pvld_reg && valid[pidx_reg];

    lobm_cmp u_cmp (
        .cand      (rd_data),
        .cand_valid(cand_valid),
        .best      (best_reg),
        .have_best (have_best_reg),
        .symbol    (sym_reg),
        .side      (side_reg),
        .limit     (price_reg),
        .take      (take)
    );

    assign scan_done = (cnt_reg == N_CNT) && !pvld_reg;
    assign fill_vol  = (best_reg.volume < rem_reg) ? best_reg.volume : rem_reg;
    assign new_stamp = !((ent_reg.price == price_reg) && (ent_reg.volume >= rem_reg));

    // final status of the request
    always_comb begin
        st       = ST_BAD_CMD;
        st_sym   = 8'd0;
        st_price = 32'd0;
        st_vol   = 32'd0;
        unique case (cmd_reg)
            CMD_INSERT: begin
                st_sym   = sym_reg;
                st_price = price_reg;
                if (found_reg) begin
                    st = ST_DUPLICATE;
                end else if (rem_reg == 32'd0) begin
                    st = ST_FILLED;
                end else if (!free_ok_reg) begin
                    st     = ST_FULL;
                    st_vol = rem_reg;
                end else begin
                    st     = ST_RESTED;
                    st_vol = rem_reg;
                end
            end
            CMD_AMEND: begin
                if (!found_reg) begin
                    st = ST_UNKNOWN;
                end else begin
                    st_sym   = sym_reg;
                    st_price = price_reg;
                    st_vol   = rem_reg;
                    st       = (rem_reg == 32'd0) ? ST_FILLED : ST_RESTED;
                end
            end
            CMD_PULL: begin
                if (!found_reg) begin
                    st = ST_UNKNOWN;
                end else begin
                    st       = ST_RESTED;
                    st_sym   = ent_reg.symbol;
                    st_price = ent_reg.price;
                end
            end
            default: begin
                st = ST_BAD_CMD;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser == CMD_BAD) ? S_DONE : S_FIND;
                end
            end
            S_FIND: begin
                if (scan_done) begin
                    if (cmd_reg == CMD_PULL || found_reg == (cmd_reg == CMD_INSERT)
                        || rem_reg == 32'd0) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_MATCH;
                    end
                end
            end
            S_MATCH: begin
                if (scan_done) begin
                    if (have_best_reg) begin
                        state_next = S_FILL;
                    end else if (cmd_reg == CMD_INSERT) begin
                        state_next = S_FREE;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_FILL: state_next = S_OUT;
            S_FREE: begin
                if (cnt_reg == N_CNT || !valid[cnt_reg[IDX_W-1:0]]) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: state_next = S_OUT;
            S_OUT: begin
                if (m_tready) begin
                    if (!ret_match_reg) begin
                        state_next = S_IDLE;
                    end else if (rem_reg == 32'd0) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_MATCH;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // sequencer outputs: handshake, book read and write
    always_comb begin
        s_tready = (state_reg == S_IDLE);
        rd_addr  = (cnt_reg < N_CNT) ? cnt_reg[IDX_W-1:0] : '0;
        wr_ctl   = '0;
        wr_addr  = eidx_reg;
        wr_data  = best_reg;
        unique case (state_reg)
            S_FILL: begin
                wr_ctl.we        = 1'b1;
                wr_ctl.clr_valid = (best_reg.volume == fill_vol);
                wr_addr          = bidx_reg;
                wr_data.volume   = best_reg.volume - fill_vol;
            end
            S_DONE: begin
                wr_data.order_id = id_reg;
                wr_data.symbol   = sym_reg;
                wr_data.side     = side_reg;
                wr_data.price    = price_reg;
                wr_data.volume   = rem_reg;
                wr_data.stamp    = stamp_reg;
                if (cmd_reg == CMD_INSERT && st == ST_RESTED) begin
                    wr_ctl.we        = 1'b1;
                    wr_ctl.set_valid = 1'b1;
                    wr_addr          = fidx_reg;
                end else if (cmd_reg == CMD_AMEND && st == ST_RESTED) begin
                    wr_ctl.we = 1'b1;
                end else if ((cmd_reg == CMD_AMEND || cmd_reg == CMD_PULL) && found_reg) begin
                    // amend to nothing left, or pull
                    wr_ctl.clr_valid = 1'b1;
                end
            end
            default: begin
                wr_ctl = '0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        sym_next       = sym_reg;
        side_next      = side_reg;
        price_next     = price_reg;
        rem_next       = rem_reg;
        stamp_next     = stamp_reg;
        seq_next       = seq_reg;
        found_next     = found_reg;
        eidx_next      = eidx_reg;
        ent_next       = ent_reg;
        cnt_next       = cnt_reg;
        pvld_next      = 1'b0;
        pidx_next      = pidx_reg;
        have_best_next = have_best_reg;
        bidx_next      = bidx_reg;
        best_next      = best_reg;
        free_ok_next   = free_ok_reg;
        fidx_next      = fidx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;
        ret_match_next = ret_match_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next     = s_tuser;
                    id_next      = s_tdata[31:0];
                    sym_next     = s_tdata[39:32];
                    side_next    = s_tdata[40];
                    price_next   = s_tdata[72:41];
                    rem_next     = s_tdata[104:73];
                    found_next   = 1'b0;
                    free_ok_next = 1'b0;
                end
            end
            S_FIND: begin
                if (cnt_reg < N_CNT) begin
                    cnt_next  = cnt_reg + 1'b1;
                    pvld_next = 1'b1;
                    pidx_next = cnt_reg[IDX_W-1:0];
                end
                if (cand_valid && rd_data.order_id == id_reg) begin
                    found_next = 1'b1;
                    eidx_next  = pidx_reg;
                    ent_next   = rd_data;
                end
                if (scan_done) begin
                    if (cmd_reg == CMD_INSERT && !found_reg) begin
                        seq_next   = seq_reg + 32'd1;
                        stamp_next = seq_reg + 32'd1;
                    end else if (cmd_reg == CMD_AMEND && found_reg) begin
                        sym_next  = ent_reg.symbol;
                        side_next = ent_reg.side;
                        if (new_stamp) begin
                            seq_next   = seq_reg + 32'd1;
                            stamp_next = seq_reg + 32'd1;
                        end else begin
                            stamp_next = ent_reg.stamp;
                        end
                    end
                end
            end
            S_MATCH: begin
                if (cnt_reg < N_CNT) begin
                    cnt_next  = cnt_reg + 1'b1;
                    pvld_next = 1'b1;
                    pidx_next = cnt_reg[IDX_W-1:0];
                end
                if (take) begin
                    have_best_next = 1'b1;
                    bidx_next      = pidx_reg;
                    best_next      = rd_data;
                end
            end
            S_FILL: begin
                rem_next       = rem_reg - fill_vol;
                out_valid_next = 1'b1;
                out_kind_next  = 1'b0;
                out_data_next  = {fill_vol, best_reg.price, sym_reg, best_reg.order_id,
                                  id_reg, ST_RESTED};
                ret_match_next = 1'b1;
            end
            S_FREE: begin
                if (cnt_reg != N_CNT) begin
                    if (!valid[cnt_reg[IDX_W-1:0]]) begin
                        free_ok_next = 1'b1;
                        fidx_next    = cnt_reg[IDX_W-1:0];
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            S_DONE: begin
                out_valid_next = 1'b1;
                out_kind_next  = 1'b1;
                out_data_next  = {st_vol, st_price, st_sym, 32'd0, id_reg, st};
                ret_match_next = 1'b0;
            end
            S_OUT: begin
                if (m_tready) begin
                    out_valid_next = 1'b0;
                end
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase

        // fresh scan on every change of state, the free slot result is kept for the status
        if (state_next != state_reg) begin
            cnt_next       = '0;
            pvld_next      = 1'b0;
            have_best_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            seq_reg       <= 32'd0;
            cnt_reg       <= '0;
            pvld_reg      <= 1'b0;
            have_best_reg <= 1'b0;
            free_ok_reg   <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            ret_match_reg <= 1'b0;
            cmd_reg       <= CMD_BAD;
        end else begin
            state_reg     <= state_next;
            seq_reg       <= seq_next;
            cnt_reg       <= cnt_next;
            pvld_reg      <= pvld_next;
            have_best_reg <= have_best_next;
            free_ok_reg   <= free_ok_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            ret_match_reg <= ret_match_next;
            cmd_reg       <= cmd_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        id_reg       <= id_next;
        sym_reg      <= sym_next;
        side_reg     <= side_next;
        price_reg    <= price_next;
        rem_reg      <= rem_next;
        stamp_reg    <= stamp_next;
        eidx_reg     <= eidx_next;
        ent_reg      <= ent_next;
        pidx_reg     <= pidx_next;
        bidx_reg     <= bidx_next;
        best_reg     <= best_next;
        fidx_reg     <= fidx_next;
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_data_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_kind_reg;

`ifndef SYNTHESIS
    // a new request is never taken while a result transaction is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("request taken while a result is pending");

    // trades never carry zero volume
    a_trade_vol: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[138:107] != 32'd0))
        else $error("zero-volume trade");

    // status comes last, trades never close a request
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == m_tuser))
        else $error("tlast does not match result kind");

    // after a status transaction the block returns to idle
    a_back_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tuser) |=> s_tready)
        else $error("not idle after status");
`endif

endmodule

// ===== rtl/lobm_book.sv =====
// book storage: entry memory with registered read and per-entry valid flags
`timescale 1ns / 1ps
module lobm_book #(
    parameter int BOOK_ENTRIES = lobm_pkg::BOOK_ENTRIES_DEF,
    localparam int IDX_W = (BOOK_ENTRIES > 1) ? $clog2(BOOK_ENTRIES) : 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [IDX_W-1:0]        rd_addr,
    output lobm_pkg::entry_t        rd_data,
    input  lobm_pkg::book_wr_t      wr_ctl,
    input  logic [IDX_W-1:0]        wr_addr,
    input  lobm_pkg::entry_t        wr_data,
    output logic [BOOK_ENTRIES-1:0] valid
);
    import lobm_pkg::*;

    entry_t mem [BOOK_ENTRIES];
    logic [BOOK_ENTRIES-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_ctl.we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_ctl.set_valid) begin
            valid_reg[wr_addr] <= 1'b1;
        end else if (wr_ctl.clr_valid) begin
            valid_reg[wr_addr] <= 1'b0;
        end
    end

    assign valid = valid_reg;

endmodule

// ===== rtl/lobm_cmp.sv =====
// shared compare unit: eligibility and price-time priority of one candidate
`timescale 1ns / 1ps
module lobm_cmp (
    input  lobm_pkg::entry_t cand,
    input  logic             cand_valid,
    input  lobm_pkg::entry_t best,
    input  logic             have_best,
    input  logic [7:0]       symbol,
    input  logic             side,
    input  logic [31:0]      limit,
    output logic             take
);
    import lobm_pkg::*;

    logic price_ok;
    logic better;

    always_comb begin
        price_ok = side ? (cand.price >= limit) : (cand.price <= limit);
        if (!have_best) begin
            better = 1'b1;
        end else if (cand.price != best.price) begin
            better = side ? (cand.price > best.price) : (cand.price < best.price);
        end else begin
            better = cand.stamp < best.stamp;
        end
        take = cand_valid && (cand.symbol == symbol) && (cand.side != side)
            && price_ok && better;
    end

endmodule
